// ----- hw/rtl/pt3_pkg.sv -----
// ---------------------------------------------------------------------------
// pt3_pkg: shared definitions for the 3D point transform unit
// Widths, operation codes, CORDIC constants and the pipeline item type.
// ---------------------------------------------------------------------------
package pt3_pkg;

   localparam int COORD_WIDTH      = 32;
   localparam int FRACTION_BITS    = 16;
   localparam int ANGLE_WIDTH      = 16;
   localparam int VALUE_WIDTH      = 2 * COORD_WIDTH - FRACTION_BITS;
   localparam int ROT_WIDTH        = COORD_WIDTH + 2;
   localparam int TRIG_WIDTH       = 32;
   localparam int TRIG_FRAC        = 30;
   localparam int PROD_WIDTH       = TRIG_WIDTH + ROT_WIDTH - TRIG_FRAC;
   localparam int ANGLE_FULL_WIDTH = 32;
   localparam int Z_WIDTH          = ANGLE_FULL_WIDTH + 2;
   localparam int TRIG_ITERS       = 30;
   localparam int ITERS_PER_STAGE  = 3;
   localparam int CORDIC_STAGES    = TRIG_ITERS / ITERS_PER_STAGE;
   localparam int ENTRY_DELAY      = CORDIC_STAGES + 2;
   localparam int LATENCY          = ENTRY_DELAY + 7;

   localparam logic signed [TRIG_WIDTH-1:0] TRIG_GAIN = 32'sd652032874;

   localparam logic signed [Z_WIDTH-1:0] ATAN_TABLE [TRIG_ITERS] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
      34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772, 34'sd166886,
      34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608,
      34'sd1304, 34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41, 34'sd20,
      34'sd10, 34'sd5, 34'sd3, 34'sd1
   };

   localparam logic [2:0] KIND_SCALE     = 3'd0;
   localparam logic [2:0] KIND_TRANSLATE = 3'd1;
   localparam logic [2:0] KIND_ROTATE    = 3'd2;
   localparam logic [2:0] KIND_NEGATE    = 3'd3;
   localparam logic [2:0] KIND_AROUND    = 3'd4;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [TRIG_WIDTH-1:0]  trig_type;

   typedef struct packed {
      logic                  valid;
      logic [2:0]            kind;
      value_type [2:0]       p;
      coord_type [2:0]       center;
      trig_type [2:0]        cosine;
      trig_type [2:0]        sine;
   } item_type;

endpackage

// ----- hw/rtl/pt3_cordic.sv -----
// ---------------------------------------------------------------------------
// pt3_cordic: pipelined sine and cosine of a binary angle
// Folds the angle into the right half plane, then runs three CORDIC
// iterations per register stage and undoes the fold at the output.
// ---------------------------------------------------------------------------
module pt3_cordic (
   input  logic                             clock,
   input  logic [pt3_pkg::ANGLE_WIDTH-1:0]  angle_in,
   output pt3_pkg::trig_type                cosine_out,
   output pt3_pkg::trig_type                sine_out
);

   logic [pt3_pkg::ANGLE_FULL_WIDTH-1:0] ang_full;
   logic                                 fold;
   logic signed [pt3_pkg::Z_WIDTH-1:0]   z_start;

   logic signed [pt3_pkg::TRIG_WIDTH-1:0] x_ff [pt3_pkg::CORDIC_STAGES+1];
   logic signed [pt3_pkg::TRIG_WIDTH-1:0] y_ff [pt3_pkg::CORDIC_STAGES+1];
   logic signed [pt3_pkg::Z_WIDTH-1:0]    z_ff [pt3_pkg::CORDIC_STAGES+1];
   logic                                  fold_ff [pt3_pkg::CORDIC_STAGES+1];
   pt3_pkg::trig_type                     cosine_ff;
   pt3_pkg::trig_type                     sine_ff;

   assign ang_full = {angle_in, {(pt3_pkg::ANGLE_FULL_WIDTH - pt3_pkg::ANGLE_WIDTH){1'b0}}};
   assign fold     = ang_full[pt3_pkg::ANGLE_FULL_WIDTH-1] ^ ang_full[pt3_pkg::ANGLE_FULL_WIDTH-2];
   assign z_start  = pt3_pkg::Z_WIDTH'($signed({ang_full[pt3_pkg::ANGLE_FULL_WIDTH-1] ^ fold,
                                                ang_full[pt3_pkg::ANGLE_FULL_WIDTH-2:0]}));

   always_ff @(posedge clock) begin
      x_ff[0]    <= pt3_pkg::TRIG_GAIN;
      y_ff[0]    <= '0;
      z_ff[0]    <= z_start;
      fold_ff[0] <= fold;
   end

   for (genvar s = 0; s < pt3_pkg::CORDIC_STAGES; s++) begin : g_stage
      logic signed [pt3_pkg::TRIG_WIDTH-1:0] x_in;
      logic signed [pt3_pkg::TRIG_WIDTH-1:0] y_in;
      logic signed [pt3_pkg::Z_WIDTH-1:0]    z_in;

      always_comb begin
         logic signed [pt3_pkg::TRIG_WIDTH-1:0] xv;
         logic signed [pt3_pkg::TRIG_WIDTH-1:0] yv;
         logic signed [pt3_pkg::TRIG_WIDTH-1:0] dx;
         logic signed [pt3_pkg::TRIG_WIDTH-1:0] dy;
         logic signed [pt3_pkg::Z_WIDTH-1:0]    zv;
         xv = x_ff[s];
         yv = y_ff[s];
         zv = z_ff[s];
         for (int j = 0; j < pt3_pkg::ITERS_PER_STAGE; j++) begin
            dx = yv >>> (s * pt3_pkg::ITERS_PER_STAGE + j);
            dy = xv >>> (s * pt3_pkg::ITERS_PER_STAGE + j);
            if (!zv[pt3_pkg::Z_WIDTH-1]) begin
               xv = xv - dx;
               yv = yv + dy;
               zv = zv - pt3_pkg::ATAN_TABLE[s * pt3_pkg::ITERS_PER_STAGE + j];
            end else begin
               xv = xv + dx;
               yv = yv - dy;
               zv = zv + pt3_pkg::ATAN_TABLE[s * pt3_pkg::ITERS_PER_STAGE + j];
            end
         end
         x_in = xv;
         y_in = yv;
         z_in = zv;
      end

      always_ff @(posedge clock) begin
         x_ff[s+1]    <= x_in;
         y_ff[s+1]    <= y_in;
         z_ff[s+1]    <= z_in;
         fold_ff[s+1] <= fold_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      cosine_ff <= fold_ff[pt3_pkg::CORDIC_STAGES] ? -x_ff[pt3_pkg::CORDIC_STAGES]
                                                   : x_ff[pt3_pkg::CORDIC_STAGES];
      sine_ff   <= fold_ff[pt3_pkg::CORDIC_STAGES] ? -y_ff[pt3_pkg::CORDIC_STAGES]
                                                   : y_ff[pt3_pkg::CORDIC_STAGES];
   end

   assign cosine_out = cosine_ff;
   assign sine_out   = sine_ff;

endmodule

// ----- hw/rtl/pt3_turn.sv -----
// ---------------------------------------------------------------------------
// pt3_turn: planar rotation of two coordinates about one axis
// First stage forms the four products, second stage the two sums. Items
// that are not rotations pass through unchanged.
// ---------------------------------------------------------------------------
module pt3_turn (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         axis,
   input  pt3_pkg::item_type  item_in,
   output pt3_pkg::item_type  item_out
);

   logic [1:0] idx_a;
   logic [1:0] idx_b;

   logic signed [pt3_pkg::ROT_WIDTH-1:0]  ra;
   logic signed [pt3_pkg::ROT_WIDTH-1:0]  rb;
   logic signed [pt3_pkg::TRIG_WIDTH-1:0] c;
   logic signed [pt3_pkg::TRIG_WIDTH-1:0] s;
   logic signed [pt3_pkg::TRIG_WIDTH+pt3_pkg::ROT_WIDTH-1:0] pca, psb, psa, pcb;

   pt3_pkg::item_type                     item1_ff;
   pt3_pkg::item_type                     item2_ff;
   pt3_pkg::item_type                     item2_in;
   logic signed [pt3_pkg::PROD_WIDTH-1:0] pca_ff, psb_ff, psa_ff, pcb_ff;
   logic signed [pt3_pkg::PROD_WIDTH-1:0] na, nb;
   logic                                  rotating;

   always_comb begin
      unique case (axis)
         pt3_pkg::AXIS_X: begin
            idx_a = 2'd1;
            idx_b = 2'd2;
         end
         pt3_pkg::AXIS_Y: begin
            idx_a = 2'd2;
            idx_b = 2'd0;
         end
         default: begin
            idx_a = 2'd0;
            idx_b = 2'd1;
         end
      endcase
   end

   assign ra  = $signed(item_in.p[idx_a][pt3_pkg::ROT_WIDTH-1:0]);
   assign rb  = $signed(item_in.p[idx_b][pt3_pkg::ROT_WIDTH-1:0]);
   assign c   = $signed(item_in.cosine[axis]);
   assign s   = $signed(item_in.sine[axis]);
   assign pca = c * ra;
   assign psb = s * rb;
   assign psa = s * ra;
   assign pcb = c * rb;

   always_ff @(posedge clock) begin
      if (reset) begin
         item1_ff.valid <= 1'b0;
      end else begin
         item1_ff <= item_in;
         pca_ff   <= pca[pt3_pkg::TRIG_WIDTH+pt3_pkg::ROT_WIDTH-1:pt3_pkg::TRIG_FRAC];
         psb_ff   <= psb[pt3_pkg::TRIG_WIDTH+pt3_pkg::ROT_WIDTH-1:pt3_pkg::TRIG_FRAC];
         psa_ff   <= psa[pt3_pkg::TRIG_WIDTH+pt3_pkg::ROT_WIDTH-1:pt3_pkg::TRIG_FRAC];
         pcb_ff   <= pcb[pt3_pkg::TRIG_WIDTH+pt3_pkg::ROT_WIDTH-1:pt3_pkg::TRIG_FRAC];
      end
   end

   assign na       = pca_ff - psb_ff;
   assign nb       = psa_ff + pcb_ff;
   assign rotating = (item1_ff.kind == pt3_pkg::KIND_ROTATE) ||
                     (item1_ff.kind == pt3_pkg::KIND_AROUND);

   always_comb begin
      item2_in = item1_ff;
      if (rotating) begin
         item2_in.p[idx_a] = pt3_pkg::VALUE_WIDTH'(na);
         item2_in.p[idx_b] = pt3_pkg::VALUE_WIDTH'(nb);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item2_ff.valid <= 1'b0;
      end else begin
         item2_ff <= item2_in;
      end
   end

   assign item_out = item2_ff;

endmodule

// ----- hw/rtl/point_transform_3d_unit.sv -----
// ---------------------------------------------------------------------------
// point_transform_3d_unit: scale, translate, negate or rotate a 3D point
// Q16.16 points; Euler rotation about X, then Y, then Z with CORDIC
// sine and cosine; saturated results with an overflow flag.
//
//   channel   handshake             payload
//   request   start, busy           req_kind, req_point_*, req_operand_*,
//                                   req_center_*
//   result    rsp_valid (strobe)    rsp_out_x/y/z, rsp_overflow
//
// One request is taken in every cycle; busy is always low.
// Each result follows its request through the angle register, the ten
// CORDIC stages, the sign-fix register, the three two-stage axis
// rotations and the output register.
// Synchronous reset empties the pipeline; no result follows a request
// taken before reset. The result side never stalls.
// ---------------------------------------------------------------------------
module point_transform_3d_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_kind,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [31:0] req_operand_x,
   input  logic signed [31:0] req_operand_y,
   input  logic signed [31:0] req_operand_z,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   output logic              rsp_valid,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic              rsp_overflow
);

   pt3_pkg::coord_type pt [3];
   pt3_pkg::coord_type op [3];
   pt3_pkg::coord_type ce [3];
   pt3_pkg::item_type  entry_in;
   pt3_pkg::item_type  d_ff [pt3_pkg::ENTRY_DELAY];
   pt3_pkg::item_type  turn_x_in;
   pt3_pkg::item_type  turn_y_in;
   pt3_pkg::item_type  turn_z_in;
   pt3_pkg::item_type  turn_z_out;
   pt3_pkg::trig_type  cos_v [3];
   pt3_pkg::trig_type  sin_v [3];

   pt3_pkg::coord_type out_in [3];
   logic               ov_in;
   pt3_pkg::coord_type out_ff [3];
   logic               ov_ff;
   logic               valid_ff;

   localparam pt3_pkg::value_type SAT_MAX =
      pt3_pkg::VALUE_WIDTH'({1'b0, {(pt3_pkg::COORD_WIDTH-1){1'b1}}});
   localparam pt3_pkg::value_type SAT_MIN = -SAT_MAX - 1;

   assign busy  = 1'b0;
   assign pt[0] = req_point_x;
   assign pt[1] = req_point_y;
   assign pt[2] = req_point_z;
   assign op[0] = req_operand_x;
   assign op[1] = req_operand_y;
   assign op[2] = req_operand_z;
   assign ce[0] = req_center_x;
   assign ce[1] = req_center_y;
   assign ce[2] = req_center_z;

   always_comb begin
      logic signed [2*pt3_pkg::COORD_WIDTH-1:0] prod;
      entry_in        = '0;
      entry_in.valid  = start;
      entry_in.kind   = req_kind;
      for (int j = 0; j < 3; j++) begin
         prod = pt[j] * op[j];
         entry_in.center[j] = ce[j];
         unique case (req_kind)
            pt3_pkg::KIND_SCALE:
               entry_in.p[j] = prod[2*pt3_pkg::COORD_WIDTH-1:pt3_pkg::FRACTION_BITS];
            pt3_pkg::KIND_TRANSLATE:
               entry_in.p[j] = pt3_pkg::VALUE_WIDTH'(pt[j]) + pt3_pkg::VALUE_WIDTH'(op[j]);
            pt3_pkg::KIND_NEGATE:
               entry_in.p[j] = -pt3_pkg::VALUE_WIDTH'(pt[j]);
            pt3_pkg::KIND_AROUND:
               entry_in.p[j] = pt3_pkg::VALUE_WIDTH'(pt[j]) - pt3_pkg::VALUE_WIDTH'(ce[j]);
            default:
               entry_in.p[j] = pt3_pkg::VALUE_WIDTH'(pt[j]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < pt3_pkg::ENTRY_DELAY; k++) begin
            d_ff[k].valid <= 1'b0;
         end
      end else begin
         d_ff[0] <= entry_in;
         for (int k = 1; k < pt3_pkg::ENTRY_DELAY; k++) begin
            d_ff[k] <= d_ff[k-1];
         end
      end
   end

   pt3_cordic u_cordic_x (
      .clock      (clock),
      .angle_in   (req_operand_x[pt3_pkg::ANGLE_WIDTH-1:0]),
      .cosine_out (cos_v[0]),
      .sine_out   (sin_v[0])
   );

   pt3_cordic u_cordic_y (
      .clock      (clock),
      .angle_in   (req_operand_y[pt3_pkg::ANGLE_WIDTH-1:0]),
      .cosine_out (cos_v[1]),
      .sine_out   (sin_v[1])
   );

   pt3_cordic u_cordic_z (
      .clock      (clock),
      .angle_in   (req_operand_z[pt3_pkg::ANGLE_WIDTH-1:0]),
      .cosine_out (cos_v[2]),
      .sine_out   (sin_v[2])
   );

   always_comb begin
      turn_x_in = d_ff[pt3_pkg::ENTRY_DELAY-1];
      for (int j = 0; j < 3; j++) begin
         turn_x_in.cosine[j] = cos_v[j];
         turn_x_in.sine[j]   = sin_v[j];
      end
   end

   pt3_turn u_turn_x (
      .clock    (clock),
      .reset    (reset),
      .axis     (pt3_pkg::AXIS_X),
      .item_in  (turn_x_in),
      .item_out (turn_y_in)
   );

   pt3_turn u_turn_y (
      .clock    (clock),
      .reset    (reset),
      .axis     (pt3_pkg::AXIS_Y),
      .item_in  (turn_y_in),
      .item_out (turn_z_in)
   );

   pt3_turn u_turn_z (
      .clock    (clock),
      .reset    (reset),
      .axis     (pt3_pkg::AXIS_Z),
      .item_in  (turn_z_in),
      .item_out (turn_z_out)
   );

   always_comb begin
      pt3_pkg::value_type q;
      ov_in = 1'b0;
      for (int j = 0; j < 3; j++) begin
         q = $signed(turn_z_out.p[j]);
         if (turn_z_out.kind == pt3_pkg::KIND_AROUND) begin
            q = q + pt3_pkg::VALUE_WIDTH'($signed(turn_z_out.center[j]));
         end
         if (q > SAT_MAX) begin
            out_in[j] = pt3_pkg::COORD_WIDTH'(SAT_MAX);
            ov_in     = 1'b1;
         end else if (q < SAT_MIN) begin
            out_in[j] = pt3_pkg::COORD_WIDTH'(SAT_MIN);
            ov_in     = 1'b1;
         end else begin
            out_in[j] = q[pt3_pkg::COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= turn_z_out.valid;
         ov_ff    <= ov_in;
         for (int j = 0; j < 3; j++) begin
            out_ff[j] <= out_in[j];
         end
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_x    = out_ff[0];
   assign rsp_out_y    = out_ff[1];
   assign rsp_out_z    = out_ff[2];
   assign rsp_overflow = ov_ff;

endmodule

// ----- hw/rtl/pt3_checker.sv -----
// ---------------------------------------------------------------------------
// pt3_checker: port-level checks for the 3D point transform unit
// Watches requests and results and checks latency and simple cases.
// ---------------------------------------------------------------------------
module pt3_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [2:0]        req_kind,
   input logic signed [31:0] req_point_x,
   input logic signed [31:0] req_point_y,
   input logic              rsp_valid,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic              rsp_overflow
);

   localparam logic signed [31:0] MOST_NEGATIVE = {1'b1, 31'b0};

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##19 rsp_valid)
      else $error("result missing after request");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, pt3_pkg::LATENCY))
      else $error("result without request");

   a_negate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_kind == pt3_pkg::KIND_NEGATE, pt3_pkg::LATENCY) &&
       $past(req_point_x != MOST_NEGATIVE, pt3_pkg::LATENCY))
      |-> (rsp_out_x == -$past(req_point_x, pt3_pkg::LATENCY)))
      else $error("negate result wrong");

   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_kind > pt3_pkg::KIND_AROUND, pt3_pkg::LATENCY))
      |-> (!rsp_overflow && rsp_out_y == $past(req_point_y, pt3_pkg::LATENCY)))
      else $error("unused kind altered the point");

endmodule

bind point_transform_3d_unit pt3_checker u_pt3_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_kind     (req_kind),
   .req_point_x  (req_point_x),
   .req_point_y  (req_point_y),
   .rsp_valid    (rsp_valid),
   .rsp_out_x    (rsp_out_x),
   .rsp_out_y    (rsp_out_y),
   .rsp_overflow (rsp_overflow)
);

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: self-checking bench for point_transform_3d_unit
// A queue-fed driver issues requests in phases of varying idle density.
// A monitor checks every result strobe against a bit-exact predictor of
// scale, translate, negate and CORDIC-based Euler rotation, including
// saturation and the overflow flag.
// ---------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic [2:0]        kind;
      logic signed [31:0] pt [3];
      logic signed [31:0] opnd [3];
      logic signed [31:0] ctr [3];
      int                idle_pct;
      bit                drain;
   } request_type;

   typedef struct {
      logic signed [31:0] pos [3];
      logic               ovf;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_kind = '0;
   logic signed [31:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic signed [31:0] req_operand_x = '0, req_operand_y = '0, req_operand_z = '0;
   logic signed [31:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic rsp_valid, rsp_overflow;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;

   request_type pending_requests [$];
   point_type   expected_points [$];
   request_type in_flight;
   int          errors = 0;

   point_transform_3d_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint mul_shift_floor(longint a, longint b, int sh);
      logic signed [127:0] wa, wb, prod, q;
      logic [127:0] mag;
      longint lim;
      wa = a;
      wb = b;
      lim = longint'(1) << 62;
      prod = wa * wb;
      mag = prod < 0 ? -prod : prod;
      mag = mag >> sh;
      if (mag > lim)
         return prod < 0 ? -lim : lim;
      q = prod >>> sh;
      return q[63:0];
   endfunction

   function automatic void cordic_sincos(logic [15:0] angle, output longint c,
                                         output longint s);
      logic [31:0] ang;
      bit fold;
      longint x, y, z, dx, dy;
      ang = {angle, 16'd0};
      fold = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (fold)
         ang = ang + 32'h8000_0000;
      z = longint'(signed'(ang));
      x = pt3_pkg::TRIG_GAIN;
      y = 0;
      for (int i = 0; i < pt3_pkg::TRIG_ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(pt3_pkg::ATAN_TABLE[i]);
         end else begin
            x += dx; y -= dy; z += longint'(pt3_pkg::ATAN_TABLE[i]);
         end
      end
      c = fold ? -x : x;
      s = fold ? -y : y;
   endfunction

   function automatic void plane_turn(inout longint a, inout longint b,
                                      input logic [15:0] angle);
      longint c, s, na, nb;
      cordic_sincos(angle, c, s);
      na = mul_shift_floor(c, a, pt3_pkg::TRIG_FRAC) -
           mul_shift_floor(s, b, pt3_pkg::TRIG_FRAC);
      nb = mul_shift_floor(s, a, pt3_pkg::TRIG_FRAC) +
           mul_shift_floor(c, b, pt3_pkg::TRIG_FRAC);
      a = na;
      b = nb;
   endfunction

   function automatic point_type transform_point(request_type r);
      longint p [3];
      point_type res;
      longint hi, lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      for (int j = 0; j < 3; j++)
         p[j] = r.pt[j];
      case (r.kind)
         pt3_pkg::KIND_SCALE: begin
            for (int j = 0; j < 3; j++)
               p[j] = mul_shift_floor(p[j], r.opnd[j], pt3_pkg::FRACTION_BITS);
         end
         pt3_pkg::KIND_TRANSLATE: begin
            for (int j = 0; j < 3; j++)
               p[j] += r.opnd[j];
         end
         pt3_pkg::KIND_NEGATE: begin
            for (int j = 0; j < 3; j++)
               p[j] = -p[j];
         end
         pt3_pkg::KIND_ROTATE, pt3_pkg::KIND_AROUND: begin
            if (r.kind == pt3_pkg::KIND_AROUND)
               for (int j = 0; j < 3; j++)
                  p[j] -= r.ctr[j];
            plane_turn(p[1], p[2], r.opnd[0][15:0]);
            plane_turn(p[2], p[0], r.opnd[1][15:0]);
            plane_turn(p[0], p[1], r.opnd[2][15:0]);
            if (r.kind == pt3_pkg::KIND_AROUND)
               for (int j = 0; j < 3; j++)
                  p[j] += r.ctr[j];
         end
         default: ;
      endcase
      res.ovf = 1'b0;
      for (int j = 0; j < 3; j++) begin
         if (p[j] > hi) begin
            p[j] = hi; res.ovf = 1'b1;
         end else if (p[j] < lo) begin
            p[j] = lo; res.ovf = 1'b1;
         end
         res.pos[j] = p[j][31:0];
      end
      return res;
   endfunction

   // Driver: records the request taken at this edge, then presents the next.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            expected_points.push_back(transform_point(in_flight));
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_requests.size() != 0 &&
                      $urandom_range(99) >= pending_requests[0].idle_pct &&
                      !(pending_requests[0].drain &&
                        (expected_points.size() != 0 || start))) begin
            in_flight = pending_requests.pop_front();
            start <= 1'b1;
            req_kind <= in_flight.kind;
            req_point_x <= in_flight.pt[0];
            req_point_y <= in_flight.pt[1];
            req_point_z <= in_flight.pt[2];
            req_operand_x <= in_flight.opnd[0];
            req_operand_y <= in_flight.opnd[1];
            req_operand_z <= in_flight.opnd[2];
            req_center_x <= in_flight.ctr[0];
            req_center_y <= in_flight.ctr[1];
            req_center_z <= in_flight.ctr[2];
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid) begin
         if (expected_points.size() == 0) begin
            $error("unexpected result x=%0d y=%0d z=%0d", rsp_out_x, rsp_out_y,
                   rsp_out_z);
            errors++;
         end else begin
            e = expected_points.pop_front();
            if (rsp_out_x !== e.pos[0]) begin
               $error("out_x expected %0d actual %0d", e.pos[0], rsp_out_x);
               errors++;
            end
            if (rsp_out_y !== e.pos[1]) begin
               $error("out_y expected %0d actual %0d", e.pos[1], rsp_out_y);
               errors++;
            end
            if (rsp_out_z !== e.pos[2]) begin
               $error("out_z expected %0d actual %0d", e.pos[2], rsp_out_z);
               errors++;
            end
            if (rsp_overflow !== e.ovf) begin
               $error("overflow expected %0d actual %0d", e.ovf, rsp_overflow);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2, 3: return $signed($urandom_range(2097151)) - 32'sd1048576;
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type make_request(logic [2:0] kind, int idle_pct);
      request_type r;
      r.kind = kind;
      r.idle_pct = idle_pct;
      r.drain = 1'b0;
      for (int j = 0; j < 3; j++) begin
         r.pt[j] = pick_coord();
         r.ctr[j] = pick_coord();
         if (kind == pt3_pkg::KIND_SCALE && $urandom_range(3) != 0)
            r.opnd[j] = $signed($urandom_range(524287)) - 32'sd262144;
         else
            r.opnd[j] = pick_coord();
      end
      return r;
   endfunction

   function automatic request_type fixed_request(logic [2:0] kind, logic signed [31:0] p,
                                                 logic signed [31:0] o,
                                                 logic signed [31:0] c);
      request_type r;
      r = make_request(kind, 0);
      for (int j = 0; j < 3; j++) begin
         r.pt[j] = p;
         r.opnd[j] = o;
         r.ctr[j] = c;
      end
      return r;
   endfunction

   initial begin
      int phase_pct [4];
      request_type r;
      logic [2:0] k;
      phase_pct = '{0, 81, 0, 29};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      pending_requests.push_back(fixed_request(pt3_pkg::KIND_SCALE, 32'sh7fff_ffff,
                                               32'sh7fff_ffff, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_SCALE, 32'sh8000_0000,
                                               32'sh7fff_ffff, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_SCALE, -32'sd3, 32'sd1, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_SCALE, 32'sd65536,
                                               32'sd131072, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_TRANSLATE, 32'sh7fff_ffff,
                                               32'sd1, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_TRANSLATE, 32'sh8000_0000,
                                               -32'sd1, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_TRANSLATE, 32'sd5,
                                               -32'sd9, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_NEGATE, 32'sh8000_0000, 0, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_NEGATE, 32'sh7fff_ffff, 0, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_NEGATE, 32'sd0, 0, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_ROTATE, 32'sd65536, 32'sd0, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_ROTATE, 32'sd65536,
                                               32'sd16384, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_ROTATE, 32'sd65536,
                                               32'sd32768, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_ROTATE, 32'sd65536,
                                               32'sd49152, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_ROTATE, 32'sh7fff_ffff,
                                               32'sh7fff_2000, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_ROTATE, 32'sh8000_0000,
                                               32'shffff_ffff, 0));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_AROUND, 32'sh7fff_ffff,
                                               32'sd8192, 32'sh8000_0000));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_AROUND, 32'sh8000_0000,
                                               32'sd32768, 32'sh7fff_ffff));
      pending_requests.push_back(fixed_request(pt3_pkg::KIND_AROUND, 32'sd1000,
                                               32'sd40000, 32'sd1000));
      pending_requests.push_back(fixed_request(3'd5, 32'sh8000_0000, 32'sd1, 32'sd1));
      pending_requests.push_back(fixed_request(3'd6, 32'sd77, 32'sd1, 32'sd1));
      pending_requests.push_back(fixed_request(3'd7, 32'sh7fff_ffff, 32'sd1, 32'sd1));

      for (int ph = 0; ph < 4; ph++) begin
         for (int n = 0; n < 335; n++) begin
            k = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                          : 3'($urandom_range(4));
            r = make_request(k, phase_pct[ph]);
            r.drain = (n == 0) || ($urandom_range(149) == 0);
            pending_requests.push_back(r);
         end
      end

      wait (pending_requests.size() == 0 && !start && expected_points.size() == 0);
      repeat (pt3_pkg::LATENCY + 5) @(posedge clock);
      if (errors == 0 && expected_points.size() == 0)
         $display("point_transform_3d_unit: match");
      else
         $display("point_transform_3d_unit: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("point_transform_3d_unit: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/pt3_pkg.sv
hw/rtl/pt3_cordic.sv
hw/rtl/pt3_turn.sv
hw/rtl/point_transform_3d_unit.sv
hw/rtl/pt3_checker.sv
verif/testbench.sv
